/* hw/rtl/transposition_table_probe_record_core_defines.svh */
// Assertion macros shared by the transposition table RTL.
`ifndef TRANSPOSITION_TABLE_PROBE_RECORD_CORE_DEFINES_SVH
`define TRANSPOSITION_TABLE_PROBE_RECORD_CORE_DEFINES_SVH

// Check a property on aclk while the block is out of reset.
`define TTPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on aclk in every cycle, reset included.
`define TTPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/ttpr_pkg.sv */
// Types and constants for the transposition table probe/record core.
`default_nettype none

package ttpr_pkg;

    // Table geometry
    localparam int unsigned DEFAULT_TABLE_ENTRIES = 65536;
    localparam int unsigned KEY_INDEX_W           = 16;
    localparam int unsigned KEY_SPAN              = 1 << KEY_INDEX_W;

    // Configuration port
    localparam int unsigned  APB_ADDR_W          = 3;
    localparam int unsigned  APB_DATA_W          = 32;
    localparam int unsigned  WIN_W               = 15;
    localparam logic [0:0]   REG_WIN_THRESHOLD   = 1'b0;
    localparam logic [14:0]  WIN_THRESHOLD_RESET = 15'd30000;

    // Operation codes of an input transfer
    typedef enum logic [1:0] {
        OP_PROBE  = 2'd0,
        OP_RECORD = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Stored bound kind
    typedef enum logic [1:0] {
        BOUND_UPPER = 2'd0,
        BOUND_LOWER = 2'd1,
        BOUND_EXACT = 2'd2
    } bound_t;

    // Stored entry payload, 42 bits
    typedef struct packed {
        logic [15:0]        move;
        logic signed [15:0] score;
        bound_t             kind;
        logic [7:0]         depth;
    } entry_payload_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/transposition_table_probe_record_core.sv */
// Direct-mapped transposition table with depth-preferred replacement.
`default_nettype none

// The table sits in two synchronous memories (check key and payload)
// addressed by key_index modulo TABLE_ENTRIES. Each transfer passes
// through a lookup state, in which the entry is read, and an execute
// state, in which the probe result is formed or the record is written
// back and the result is loaded into the register on the m_ channel.
// The execute state waits while that register holds a result that is not
// taken, and a new item is taken only in the idle state or as it finishes.
// The output register lets a new item be taken while a result still waits.
// A clear transfer returns its all-zero result and then sweeps the table,
// one entry per cycle, over all TABLE_ENTRIES entries with s_ready low; the
// same sweep runs after reset, so s_ready first rises when the sweep ends
// after aresetn goes high. win_threshold may be written over the APB port
// at any time; it is meant to change only while no transfer is in flight.

`include "transposition_table_probe_record_core_defines.svh"

module transposition_table_probe_record_core
    import ttpr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = DEFAULT_TABLE_ENTRIES
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    // APB configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic      [APB_DATA_W-1:0]   prdata,
    output logic                         pready,

    // Input channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_op,
    input  wire logic [15:0]             s_key_index,
    input  wire logic [31:0]             s_check_key,
    input  wire logic [7:0]              s_search_depth,
    input  wire logic [1:0]              s_bound_kind,
    input  wire logic signed [15:0]      s_score,
    input  wire logic [15:0]             s_store_move,
    input  wire logic signed [15:0]      s_alpha,
    input  wire logic signed [15:0]      s_beta,

    // Result channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_score_valid,
    output logic signed [15:0]           m_found_score,
    output logic [15:0]                  m_found_move
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [WIN_W-1:0] win_reg;
    logic             cfg_wr;
    logic             cfg_hit;

    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_WIN_THRESHOLD);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? APB_DATA_W'(win_reg) : '0;

    // Update the threshold on a completed write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= WIN_THRESHOLD_RESET;
        end else if (cfg_wr && cfg_hit) begin
            win_reg <= pwdata[WIN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Controller and item registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               s_accept;
    logic               out_free;
    logic               exec_fire;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [31:0]        wr_chk;
    entry_payload_t     wr_pay;
    logic               replace;

    op_t                op_reg;
    logic [15:0]        key_reg;
    logic [31:0]        chk_in_reg;
    logic [7:0]         depth_reg;
    bound_t             kind_reg;
    logic signed [15:0] score_reg;
    logic [15:0]        move_reg;
    logic signed [15:0] alpha_reg;
    logic signed [15:0] beta_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   lookup_idx;

    logic [31:0]        rd_chk_reg;
    entry_payload_t     rd_pay_reg;

    logic               m_valid_reg;
    logic               m_score_valid_reg;
    logic signed [15:0] m_found_score_reg;
    logic [15:0]        m_found_move_reg;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Capture the item on an input transfer
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg     <= op_t'(s_op);
            key_reg    <= s_key_index;
            chk_in_reg <= s_check_key;
            depth_reg  <= s_search_depth;
            kind_reg   <= bound_t'(s_bound_kind);
            score_reg  <= s_score;
            move_reg   <= s_store_move;
            alpha_reg  <= s_alpha;
            beta_reg   <= s_beta;
        end
    end

    // ------------------------------------------------------------------
    // Entry index: key_index modulo TABLE_ENTRIES
    // ------------------------------------------------------------------
    generate
        if (TABLE_ENTRIES >= KEY_SPAN) begin : g_idx_wide
            assign lookup_idx = IDX_W'(key_reg);
        end else if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_idx_mask
            assign lookup_idx = key_reg[IDX_W-1:0];
        end else begin : g_idx_recip
            // Quotient by reciprocal multiply, exact for 16-bit keys
            localparam logic [31:0] RECIP =
                32'(((64'd1 << 32) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES));
            localparam logic [15:0] MODULUS = 16'(TABLE_ENTRIES);
            logic [47:0] quot_prod;
            logic [15:0] quot_reg;
            logic [31:0] back_prod;
            logic [15:0] rem;

            assign quot_prod = 48'(s_key_index) * 48'(RECIP);

            // Hold the quotient for the lookup cycle
            always_ff @(posedge aclk) begin
                if (s_accept) begin
                    quot_reg <= quot_prod[47:32];
                end
            end

            assign back_prod  = 32'(quot_reg) * 32'(MODULUS);
            assign rem        = key_reg - back_prod[15:0];
            assign lookup_idx = rem[IDX_W-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Table memories: one write and one read port, never used together
    // ------------------------------------------------------------------
    logic [31:0]    chk_mem [TABLE_ENTRIES];
    entry_payload_t pay_mem [TABLE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            chk_mem[wr_addr] <= wr_chk;
            pay_mem[wr_addr] <= wr_pay;
        end
        if (rd_en) begin
            rd_chk_reg <= chk_mem[lookup_idx];
            rd_pay_reg <= pay_mem[lookup_idx];
        end
    end

    // Keep the entry index for the write-back
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            idx_reg <= lookup_idx;
        end
    end

    // ------------------------------------------------------------------
    // Probe evaluation on the entry read in the lookup cycle
    // ------------------------------------------------------------------
    logic               key_hit;
    logic signed [16:0] score_ext;
    logic signed [16:0] win_pos;
    logic signed [16:0] win_neg;
    logic               mate;
    logic               depth_ok;
    logic               bound_ok;
    logic               res_score_valid;
    logic signed [15:0] res_found_score;
    logic [15:0]        res_found_move;

    assign key_hit   = (rd_chk_reg == chk_in_reg);
    assign score_ext = 17'(rd_pay_reg.score);
    assign win_pos   = $signed({2'b00, win_reg});
    assign win_neg   = -win_pos;
    assign mate      = (score_ext > win_pos) || (score_ext < win_neg);
    assign depth_ok  = (rd_pay_reg.depth >= depth_reg) || mate;
    assign replace   = (rd_pay_reg.depth <= depth_reg);

    // Apply the bound test of the stored entry
    always_comb begin
        unique case (rd_pay_reg.kind)
            BOUND_UPPER: bound_ok = (rd_pay_reg.score <= alpha_reg);
            BOUND_LOWER: bound_ok = (rd_pay_reg.score >= beta_reg);
            BOUND_EXACT: bound_ok = 1'b1;
            default:     bound_ok = 1'b0;
        endcase
    end

    // Form the result; record, clear and the unused code return zeros
    always_comb begin
        res_score_valid = 1'b0;
        res_found_score = '0;
        res_found_move  = '0;
        unique case (op_reg)
            OP_PROBE: begin
                if (key_hit) begin
                    res_found_move = rd_pay_reg.move;
                    if (depth_ok && bound_ok) begin
                        res_score_valid = 1'b1;
                        res_found_score = rd_pay_reg.score;
                    end
                end
            end
            OP_RECORD, OP_CLEAR: begin
                res_score_valid = 1'b0;
            end
            default: begin
                res_score_valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next state, memory control and handshake
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        s_ready      = 1'b0;
        rd_en        = 1'b0;
        exec_fire    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_chk       = chk_in_reg;
        wr_pay       = '{move: move_reg, score: score_reg, kind: kind_reg, depth: depth_reg};
        unique case (state_reg)
            ST_CLEAR: begin
                // Zero one entry per cycle
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_chk       = '0;
                wr_pay       = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                rd_en      = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // Finish only when the result register can take the result
                if (out_free) begin
                    exec_fire = 1'b1;
                    wr_en     = (op_reg == OP_RECORD) && replace;
                    if (op_reg == OP_CLEAR) begin
                        clr_cnt_next = '0;
                        state_next   = ST_CLEAR;
                    end else begin
                        s_ready    = 1'b1;
                        state_next = s_valid ? ST_LOOKUP : ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the controller; reset starts the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_score_valid_reg <= res_score_valid;
            m_found_score_reg <= res_found_score;
            m_found_move_reg  <= res_found_move;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_score_valid = m_score_valid_reg;
    assign m_found_score = m_found_score_reg;
    assign m_found_move  = m_found_move_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TTPR_ASSERT_ALWAYS(a_reset_sweep, !aresetn |=> state_reg == ST_CLEAR && !m_valid_reg, "no sweep")
    `TTPR_ASSERT(a_port_exclusive, !(wr_en && rd_en), "read and write in one cycle")
    `TTPR_ASSERT(a_write_source, wr_en |-> state_reg == ST_CLEAR || op_reg == OP_RECORD, "stray write")
    `TTPR_ASSERT(a_accept_to_lookup, s_accept |=> state_reg == ST_LOOKUP, "no lookup after transfer")
    `TTPR_ASSERT(a_zero_score, m_valid && !m_score_valid |-> m_found_score == '0, "score not zero")

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for the transposition table probe/record core: prediction, checking and stimulus.
`timescale 1ns / 100ps

module tb
    import ttpr_pkg::*;
();

    localparam logic [1:0]            OP_UNUSED      = 2'd3;
    localparam logic [1:0]            BOUND_RESERVED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] WIN_ADDR       = APB_ADDR_W'(REG_WIN_THRESHOLD) << 2;
    localparam int                    WATCHDOG_LIMIT = 200000;
    localparam int                    HOT_N          = 12;

    // One input transfer
    typedef struct {
        logic [1:0]         op;
        logic [15:0]        key_index;
        logic [31:0]        check_key;
        logic [7:0]         depth;
        logic [1:0]         kind;
        logic signed [15:0] score;
        logic [15:0]        move;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } tt_req_t;

    // One result transfer
    typedef struct {
        logic               score_valid;
        logic signed [15:0] score;
        logic [15:0]        move;
    } tt_res_t;

    // Stored entry; bound kind kept as raw bits so the reserved code survives
    typedef struct packed {
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [1:0]         kind;
        logic [7:0]         depth;
    } tt_slot_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_op;
    logic [15:0]             s_key_index;
    logic [31:0]             s_check_key;
    logic [7:0]              s_search_depth;
    logic [1:0]              s_bound_kind;
    logic signed [15:0]      s_score;
    logic [15:0]             s_store_move;
    logic signed [15:0]      s_alpha;
    logic signed [15:0]      s_beta;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_score_valid;
    logic signed [15:0]      m_found_score;
    logic [15:0]             m_found_move;

    // Shadow of the table and the threshold register
    logic [31:0]   tbl_check [KEY_SPAN];
    tt_slot_t      tbl_slot [KEY_SPAN];
    logic [14:0]   win_thresh;

    tt_res_t       pending_results [$];
    tt_res_t       head_res;
    int            mismatch_count;
    int            idle_cycles;
    int            sink_left;
    bit            sink_stalls;
    logic [15:0]   hot_index [HOT_N];
    logic [31:0]   hot_check [4];

    transposition_table_probe_record_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_key_index    (s_key_index),
        .s_check_key    (s_check_key),
        .s_search_depth (s_search_depth),
        .s_bound_kind   (s_bound_kind),
        .s_score        (s_score),
        .s_store_move   (s_store_move),
        .s_alpha        (s_alpha),
        .s_beta         (s_beta),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_score_valid  (m_score_valid),
        .m_found_score  (m_found_score),
        .m_found_move   (m_found_move)
    );

    always #1 aclk = ~aclk;

    // Zero every shadow entry, as reset and clear do
    function automatic void wipe_table();
        foreach (tbl_check[i]) begin
            tbl_check[i] = '0;
            tbl_slot[i]  = '0;
        end
    endfunction

    // Apply one transfer to the shadow table and return the result it causes
    function automatic tt_res_t table_access(input tt_req_t r);
        tt_res_t  res;
        tt_slot_t e;
        logic     mate;
        logic     ok;
        int       w;
        res = '{1'b0, 16'sd0, 16'd0};
        ok  = 1'b0;
        case (r.op)
            OP_PROBE: begin
                if (tbl_check[r.key_index] == r.check_key) begin
                    e        = tbl_slot[r.key_index];
                    w        = int'(win_thresh);
                    mate     = (e.score > w) || (e.score < -w);
                    res.move = e.move;
                    if (e.depth >= r.depth || mate) begin
                        case (e.kind)
                            BOUND_UPPER: ok = (e.score <= r.alpha);
                            BOUND_LOWER: ok = (e.score >= r.beta);
                            BOUND_EXACT: ok = 1'b1;
                            default:     ok = 1'b0;
                        endcase
                    end
                    if (ok) begin
                        res.score_valid = 1'b1;
                        res.score       = e.score;
                    end
                end
            end
            OP_RECORD: begin
                // Depth-preferred: equal depth replaces
                if (tbl_slot[r.key_index].depth <= r.depth) begin
                    tbl_slot[r.key_index]  = '{r.move, r.score, r.kind, r.depth};
                    tbl_check[r.key_index] = r.check_key;
                end
            end
            OP_CLEAR: wipe_table();
            default: ;
        endcase
        return res;
    endfunction

    function automatic tt_req_t make_req(input logic [1:0] op, input logic [15:0] idx,
                                         input logic [31:0] chk, input logic [7:0] depth,
                                         input logic [1:0] kind, input logic signed [15:0] score,
                                         input logic [15:0] move, input logic signed [15:0] alpha,
                                         input logic signed [15:0] beta);
        tt_req_t r;
        r = '{op, idx, chk, depth, kind, score, move, alpha, beta};
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return $urandom_range(0, 3);
        else if (sel < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one item and hold it until the transfer, then predict its result
    task automatic send_item(input tt_req_t r);
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_op           <= r.op;
        s_key_index    <= r.key_index;
        s_check_key    <= r.check_key;
        s_search_depth <= r.depth;
        s_bound_kind   <= r.kind;
        s_score        <= r.score;
        s_store_move   <= r.move;
        s_alpha        <= r.alpha;
        s_beta         <= r.beta;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(table_access(r));
    endtask

    task automatic pause_source(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Drop valid and wait until every expected result has arrived
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_win_threshold(input logic [14:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIN_ADDR;
        pwdata  <= APB_DATA_W'(v);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        win_thresh = v;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic do_record(input logic [15:0] idx, input logic [31:0] chk,
                             input logic [7:0] depth, input logic [1:0] kind,
                             input logic signed [15:0] score, input logic [15:0] move);
        send_item(make_req(OP_RECORD, idx, chk, depth, kind, score, move, 16'sd0, 16'sd0));
    endtask

    task automatic do_probe(input logic [15:0] idx, input logic [31:0] chk,
                            input logic [7:0] depth, input logic signed [15:0] alpha,
                            input logic signed [15:0] beta);
        send_item(make_req(OP_PROBE, idx, chk, depth, BOUND_UPPER, 16'sd0, 16'd0, alpha, beta));
    endtask

    // Entries after reset hold check key 0 and an all-zero payload
    task automatic test_reset_contents();
        do_probe(16'd0, 32'd0, 8'd0, 16'sd0, 16'sd0);
        do_probe(16'hFFFF, 32'hFFFF_FFFF, 8'd0, 16'sd0, 16'sd0);
    endtask

    // Bound kinds, depth test, replacement rule, reserved codes
    task automatic test_record_replace();
        do_record(16'hFFFF, 32'hFFFF_FFFF, 8'd255, BOUND_EXACT, 16'sd32767, 16'hFFFF);
        do_probe(16'hFFFF, 32'hFFFF_FFFF, 8'd255, -16'sd32768, 16'sd32767);
        // shallower record must not replace
        do_record(16'hFFFF, 32'h0000_1234, 8'd10, BOUND_LOWER, 16'sd0, 16'd1);
        do_probe(16'hFFFF, 32'hFFFF_FFFF, 8'd0, 16'sd0, 16'sd0);
        do_record(16'd2, 32'hA5A5_A5A5, 8'd5, BOUND_LOWER, 16'sd100, 16'h0200);
        do_probe(16'd2, 32'hA5A5_A5A5, 8'd5, 16'sd0, 16'sd100);
        do_probe(16'd2, 32'hA5A5_A5A5, 8'd6, 16'sd0, 16'sd0);
        do_probe(16'd2, 32'hA5A5_A5A5, 8'd5, 16'sd0, 16'sd101);
        // equal depth replaces
        do_record(16'd2, 32'h5A5A_5A5A, 8'd5, BOUND_UPPER, -16'sd50, 16'h0300);
        do_probe(16'd2, 32'hA5A5_A5A5, 8'd0, 16'sd0, 16'sd0);
        do_probe(16'd2, 32'h5A5A_5A5A, 8'd0, -16'sd50, 16'sd0);
        // reserved bound kind yields the move but never a score
        do_record(16'd3, 32'd3, 8'd1, BOUND_RESERVED, 16'sd7, 16'h0400);
        do_probe(16'd3, 32'd3, 8'd0, 16'sd32767, -16'sd32768);
        // mate score skips the depth test
        do_record(16'd1, 32'd1, 8'd0, BOUND_UPPER, -16'sd32768, 16'h8000);
        do_probe(16'd1, 32'd1, 8'd255, -16'sd32768, 16'sd0);
        send_item(make_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, BOUND_RESERVED,
                           -16'sd1, 16'hFFFF, -16'sd1, -16'sd1));
        do_probe(16'd1, 32'd1, 8'd0, 16'sd32767, 16'sd0);
    endtask

    task automatic test_clear();
        send_item(make_req(OP_CLEAR, 16'h1234, 32'hDEAD_BEEF, 8'd9, BOUND_EXACT,
                           16'sd5, 16'h55, 16'sd0, 16'sd0));
        do_probe(16'd2, 32'd0, 8'd0, 16'sd0, 16'sd0);
        do_probe(16'hFFFF, 32'hFFFF_FFFF, 8'd0, 16'sd32767, -16'sd32768);
    endtask

    // Threshold extremes move scores in and out of the mate band
    task automatic test_win_threshold();
        do_record(16'd4, 32'd4, 8'd3, BOUND_LOWER, 16'sd1, 16'h0011);
        do_record(16'd5, 32'd5, 8'd0, BOUND_UPPER, -16'sd32768, 16'h0022);
        wait_results_drained();
        write_win_threshold(15'd0);
        do_probe(16'd4, 32'd4, 8'd200, 16'sd0, -16'sd32768);
        wait_results_drained();
        write_win_threshold(15'd32767);
        do_probe(16'd4, 32'd4, 8'd200, 16'sd0, -16'sd32768);
        do_probe(16'd5, 32'd5, 8'd255, 16'sd0, 16'sd0);
    endtask

    task automatic run_traffic_phase(input logic [14:0] win, input int count,
                                     input bit with_clear, input bit src_gaps,
                                     input bit sink_gaps);
        tt_req_t r;
        int      sel;
        int      v;
        wait_results_drained();
        write_win_threshold(win);
        sink_stalls = sink_gaps;
        // New hot entries each phase, keeping the extreme index and key values
        hot_index[0] = 16'd0;
        hot_index[1] = 16'hFFFF;
        for (int k = 2; k < HOT_N; k++)
            hot_index[k] = 16'($urandom);
        hot_check[0] = 32'd0;
        hot_check[1] = 32'hFFFF_FFFF;
        hot_check[2] = $urandom;
        hot_check[3] = $urandom;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (with_clear && i == count / 2)
                r.op = OP_CLEAR;
            else if (sel < 48)
                r.op = OP_PROBE;
            else if (sel < 96)
                r.op = OP_RECORD;
            else
                r.op = OP_UNUSED;
            r.key_index = ($urandom_range(0, 99) < 85) ? hot_index[$urandom_range(0, HOT_N - 1)]
                                                       : 16'($urandom);
            r.check_key = ($urandom_range(0, 99) < 80) ? hot_check[$urandom_range(0, 3)]
                                                       : 32'($urandom);
            r.depth     = ($urandom_range(0, 99) < 90) ? 8'($urandom_range(0, 7))
                                                       : 8'($urandom_range(0, 255));
            r.kind      = ($urandom_range(0, 99) < 90) ? 2'($urandom_range(0, 2))
                                                       : BOUND_RESERVED;
            // Scores near the window, near the mate band and at the extremes
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                v = int'($urandom_range(0, 40)) - 20;
            end else if (sel < 50) begin
                v = int'(win_thresh) + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    v = -v;
            end else if (sel < 60) begin
                v = $urandom_range(0, 1) ? 32767 : -32768;
            end else begin
                v = int'($urandom_range(0, 65535)) - 32768;
            end
            r.score = 16'(v);
            r.move  = 16'($urandom);
            r.alpha = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 40)) - 20)
                                           : 16'($urandom);
            r.beta  = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 40)) - 20)
                                           : 16'($urandom);
            send_item(r);
            // At the quarter mark hold the source until the block has drained; else pause it at random if src_gaps
            if (i == count / 4)
                wait_results_drained();
            else if (src_gaps && $urandom_range(0, 1))
                pause_source(pick_gap());
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(15'($urandom_range(0, 32767)), 385, 1'b0, 1'b1, 1'b1);
        run_traffic_phase(15'd0, 385, 1'b1, 1'b1, 1'b0);
        run_traffic_phase(15'd32767, 385, 1'b0, 1'b0, 1'b0);
        run_traffic_phase(15'($urandom_range(0, 32767)), 385, 1'b0, 1'b0, 1'b1);
        run_traffic_phase(WIN_THRESHOLD_RESET, 385, 1'b0, 1'b1, 1'b1);
    endtask

    // Result sink stalls
    always @(negedge aclk) begin
        if (sink_left != 0) begin
            sink_left <= sink_left - 1;
        end else if (!sink_stalls) begin
            m_ready <= 1'b1;
        end else begin
            m_ready   <= ($urandom_range(0, 99) < 60);
            sink_left <= pick_gap();
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual valid %0b score %0d move %h",
                         $time, m_score_valid, m_found_score, m_found_move);
            end else begin
                head_res = pending_results.pop_front();
                if (m_score_valid !== head_res.score_valid) begin
                    mismatch_count++;
                    $display("%0t: score_valid expected %0b actual %0b",
                             $time, head_res.score_valid, m_score_valid);
                end
                if (m_found_score !== head_res.score) begin
                    mismatch_count++;
                    $display("%0t: found_score expected %0d actual %0d",
                             $time, head_res.score, m_found_score);
                end
                if (m_found_move !== head_res.move) begin
                    mismatch_count++;
                    $display("%0t: found_move expected %h actual %h",
                             $time, head_res.move, m_found_move);
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_op           = '0;
        s_key_index    = '0;
        s_check_key    = '0;
        s_search_depth = '0;
        s_bound_kind   = '0;
        s_score        = '0;
        s_store_move   = '0;
        s_alpha        = '0;
        s_beta         = '0;
        m_ready        = 1'b1;
        sink_left      = 0;
        sink_stalls    = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        win_thresh     = WIN_THRESHOLD_RESET;
        wipe_table();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_contents();
        test_record_replace();
        test_clear();
        test_win_threshold();
        test_random_traffic();

        wait_results_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
